@@ rtl/evs_pkg.sv @@
// Package for the energy VAD segmenter: widths, register map, reason codes,
// configuration and result structs. No dependencies.
`default_nettype none

package evs_pkg;

    // Frame length limit and the widths that follow from it
    localparam int MAX_FRAME_SAMPLES = 1024;
    localparam int FRAME_CNT_W       = $clog2(MAX_FRAME_SAMPLES + 1);

    // Field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 17;
    localparam int PEAK_W    = 16;
    localparam int SUM_W     = 26;
    localparam int AVG_W     = 15;
    localparam int PAUSE_W   = 16;
    localparam int SEG_W     = 20;
    localparam int NEED_W    = AVG_W + 1 + FRAME_CNT_W;

    // APB register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register reset values
    localparam logic [AVG_W-1:0]   AVG_THR_RESET   = AVG_W'(180);
    localparam logic [AVG_W-1:0]   PEAK_THR_RESET  = AVG_W'(230);
    localparam logic [PAUSE_W-1:0] PAUSE_RESET     = PAUSE_W'(60);
    localparam logic [SEG_W-1:0]   MIN_FLUSH_RESET = SEG_W'(16000);
    localparam logic [SEG_W-1:0]   MAX_SEG_RESET   = SEG_W'(64000);

    // Register indexes (byte address is four times the index)
    typedef enum logic [2:0] {
        IDX_AVG_THR   = 3'd0,
        IDX_PEAK_THR  = 3'd1,
        IDX_PAUSE     = 3'd2,
        IDX_MIN_FLUSH = 3'd3,
        IDX_MAX_SEG   = 3'd4
    } t_cfg_idx;

    // Flush reason codes
    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_LENGTH = 2'd1,
        REASON_PAUSE  = 2'd2
    } t_flush_reason;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_thr;
        logic [AVG_W-1:0]   peak_thr;
        logic [PAUSE_W-1:0] pause_frames;
        logic [SEG_W-1:0]   min_flush;
        logic [SEG_W-1:0]   max_seg;
    } t_cfg;

    typedef struct packed {
        logic          frame_end;
        logic          speech;
        logic          flush;
        t_flush_reason reason;
        logic [SEG_W-1:0] seg_len;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/evs_if.sv @@
// Valid/ready stream interfaces for the sample words and the result words.
// Depends on evs_pkg for field widths.
`default_nettype none

interface evs_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [evs_pkg::SAMPLE_W-1:0] sample;
    logic                               frame_last;

    modport source (output valid, sample, frame_last, input ready);
    modport sink   (input valid, sample, frame_last, output ready);
endinterface

interface evs_out_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_end;
    logic                        speech_detected;
    logic                        flush;
    logic [1:0]                  flush_reason;
    logic [evs_pkg::SEG_W-1:0]   segment_length;

    modport source (output valid, frame_end, speech_detected, flush, flush_reason,
                    segment_length, input ready);
    modport sink   (input valid, frame_end, speech_detected, flush, flush_reason,
                    segment_length, output ready);
endinterface

`default_nettype wire

@@ rtl/evs_cfg_regs.sv @@
// APB register block holding the thresholds and segment limits.
// Depends on evs_pkg.
`default_nettype none

module evs_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [evs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [evs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [evs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output evs_pkg::t_cfg                       o_cfg
);

    evs_pkg::t_cfg    r_cfg;
    evs_pkg::t_cfg_idx w_idx;
    logic             w_wr;

    assign w_idx  = evs_pkg::t_cfg_idx'(paddr[evs_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avg_thr      <= evs_pkg::AVG_THR_RESET;
            r_cfg.peak_thr     <= evs_pkg::PEAK_THR_RESET;
            r_cfg.pause_frames <= evs_pkg::PAUSE_RESET;
            r_cfg.min_flush    <= evs_pkg::MIN_FLUSH_RESET;
            r_cfg.max_seg      <= evs_pkg::MAX_SEG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                evs_pkg::IDX_AVG_THR:   r_cfg.avg_thr      <= pwdata[evs_pkg::AVG_W-1:0];
                evs_pkg::IDX_PEAK_THR:  r_cfg.peak_thr     <= pwdata[evs_pkg::AVG_W-1:0];
                evs_pkg::IDX_PAUSE:     r_cfg.pause_frames <= pwdata[evs_pkg::PAUSE_W-1:0];
                evs_pkg::IDX_MIN_FLUSH: r_cfg.min_flush    <= pwdata[evs_pkg::SEG_W-1:0];
                evs_pkg::IDX_MAX_SEG:   r_cfg.max_seg      <= pwdata[evs_pkg::SEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (w_idx)
            evs_pkg::IDX_AVG_THR:   prdata = evs_pkg::APB_DATA_W'(r_cfg.avg_thr);
            evs_pkg::IDX_PEAK_THR:  prdata = evs_pkg::APB_DATA_W'(r_cfg.peak_thr);
            evs_pkg::IDX_PAUSE:     prdata = evs_pkg::APB_DATA_W'(r_cfg.pause_frames);
            evs_pkg::IDX_MIN_FLUSH: prdata = evs_pkg::APB_DATA_W'(r_cfg.min_flush);
            evs_pkg::IDX_MAX_SEG:   prdata = evs_pkg::APB_DATA_W'(r_cfg.max_seg);
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/evs_frame_core.sv @@
// Frame energy accumulation, speech decision and segment flush logic.
// Holds the frame and segment state; depends on evs_pkg.
`default_nettype none

module evs_frame_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire logic signed [evs_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_frame_last,
    input  wire evs_pkg::t_cfg                       i_cfg,
    output evs_pkg::t_result                         o_result
);

    localparam int CW = evs_pkg::FRAME_CNT_W;

    logic [evs_pkg::SUM_W-1:0]   r_sum,   n_sum;
    logic [evs_pkg::PEAK_W-1:0]  r_peak,  n_peak;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_seg,   n_seg;
    logic [evs_pkg::PAUSE_W-1:0] r_sil,   n_sil;
    logic [evs_pkg::SEG_W-1:0]   r_pend,  n_pend;

    logic [evs_pkg::MAG_W-1:0]   w_mag;
    logic [evs_pkg::SUM_W:0]     w_sum_wide;
    logic [evs_pkg::AVG_W:0]     w_avg_p1;
    logic [evs_pkg::NEED_W-1:0]  w_need;
    logic [evs_pkg::PAUSE_W-1:0] w_sil_a;
    logic                        w_seg_a;
    logic                        w_close, w_speech, w_long, w_ended, w_flush;

    // Per-sample accumulation: magnitude, saturating sum, peak and counts
    always_comb begin
        w_mag      = i_sample[evs_pkg::SAMPLE_W-1]
                   ? (evs_pkg::MAG_W'(~i_sample) + evs_pkg::MAG_W'(1))
                   : evs_pkg::MAG_W'(i_sample);
        w_sum_wide = {1'b0, r_sum} + (evs_pkg::SUM_W+1)'(w_mag);
        n_sum      = w_sum_wide[evs_pkg::SUM_W] ? '1 : w_sum_wide[evs_pkg::SUM_W-1:0];
        n_peak     = (w_mag > evs_pkg::MAG_W'(r_peak)) ? w_mag[evs_pkg::PEAK_W-1:0] : r_peak;
        n_count    = r_count + CW'(1);
        n_pend     = (r_pend == '1) ? r_pend : r_pend + evs_pkg::SEG_W'(1);
    end

    // Frame-end decision: mean test as sum >= (threshold + 1) * count, peak test and flush
    always_comb begin
        w_close  = i_frame_last || (n_count >= CW'(evs_pkg::MAX_FRAME_SAMPLES));
        w_avg_p1 = {1'b0, i_cfg.avg_thr} + (evs_pkg::AVG_W+1)'(1);
        w_need   = evs_pkg::NEED_W'(w_avg_p1) * evs_pkg::NEED_W'(n_count);
        w_speech = (evs_pkg::NEED_W'(n_sum) >= w_need) &&
                   (n_peak > evs_pkg::PEAK_W'(i_cfg.peak_thr));
        w_seg_a  = w_speech || r_seg;
        if (w_speech) begin
            w_sil_a = '0;
        end else if (r_seg && (r_sil != '1)) begin
            w_sil_a = r_sil + evs_pkg::PAUSE_W'(1);
        end else begin
            w_sil_a = r_sil;
        end
        w_long   = n_pend >= i_cfg.max_seg;
        w_ended  = w_seg_a && (w_sil_a >= i_cfg.pause_frames) && (n_pend >= i_cfg.min_flush);
        w_flush  = w_close && (w_long || w_ended);
    end

    // Result word for this sample
    always_comb begin
        o_result.frame_end = w_close;
        o_result.speech    = w_close && w_speech;
        o_result.flush     = w_flush;
        o_result.seg_len   = n_pend;
        if (!w_flush) begin
            o_result.reason = evs_pkg::REASON_NONE;
        end else if (w_long) begin
            o_result.reason = evs_pkg::REASON_LENGTH;
        end else begin
            o_result.reason = evs_pkg::REASON_PAUSE;
        end
    end

    // State update once per consumed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_peak  <= '0;
            r_count <= '0;
            r_seg   <= 1'b0;
            r_sil   <= '0;
            r_pend  <= '0;
        end else if (i_step) begin
            if (w_close) begin
                r_sum   <= '0;
                r_peak  <= '0;
                r_count <= '0;
                r_seg   <= w_flush ? 1'b0 : w_seg_a;
                r_sil   <= w_flush ? '0 : w_sil_a;
                r_pend  <= w_flush ? '0 : n_pend;
            end else begin
                r_sum   <= n_sum;
                r_peak  <= n_peak;
                r_count <= n_count;
                r_pend  <= n_pend;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/energy_vad_segmenter_core.sv @@
// Path: a sample word is held in the input register, and its result word is computed from
// it and held in the result register, which drives the output.
// Throughput: one sample word per cycle while the result register is free or being taken.
// Stalls: while a result waits, the input register takes at most one more word, then
// ready drops. Reset: synchronous, active low; clears the pipeline and all frame and
// segment state, and loads the default thresholds and limits into the registers.
`default_nettype none

module energy_vad_segmenter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    evs_in_if.sink                              i_smp,
    evs_out_if.source                           o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [evs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [evs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [evs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    evs_pkg::t_cfg    w_cfg;
    evs_pkg::t_result w_result;
    evs_pkg::t_result r_out;

    logic                                r_in_valid;
    logic signed [evs_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                                r_in_last;
    logic                                r_out_valid;
    logic                                w_adv;
    logic                                w_in_ready;

    evs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    evs_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv && r_in_valid),
        .i_sample     (r_in_sample),
        .i_frame_last (r_in_last),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    // Pipeline flow control: the result register frees when taken or empty
    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_smp.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_smp.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_smp.valid && w_in_ready) begin
            r_in_sample <= i_smp.sample;
            r_in_last   <= i_smp.frame_last;
        end
        if (w_adv && r_in_valid) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.frame_end       = r_out.frame_end;
    assign o_res.speech_detected = r_out.speech;
    assign o_res.flush           = r_out.flush;
    assign o_res.flush_reason    = r_out.reason;
    assign o_res.segment_length  = r_out.seg_len;

    // A stalled input word must hold until the result register frees
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_sample) && $stable(r_in_last)))
        else $error("input register changed while stalled");

    // An empty input register always takes a new word
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_smp.ready)
        else $error("input not ready with empty input register");

    // Flush and reason code agree, and decisions come only at frame end
    a_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.flush == (o_res.flush_reason != evs_pkg::REASON_NONE)) &&
                         (o_res.flush_reason <= evs_pkg::REASON_PAUSE)))
        else $error("flush reason inconsistent");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.flush || o_res.speech_detected)) |-> o_res.frame_end)
        else $error("speech or flush without frame end");

endmodule

`default_nettype wire
